// ===== design/icmpm_pkg.sv =====
// Package for the ICMP quoted-probe matcher.
// Holds the header offsets, ICMP type codes, register indexes and the check struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmpm_pkg;

  localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] ICMP_DEST_UNREACH  = 8'd3;

  localparam int unsigned ICMP_HDR_BYTES  = 8;
  localparam int unsigned INNER_SRC_OFF   = 12;
  localparam int unsigned INNER_DST_OFF   = 16;
  localparam int unsigned FIELD_BYTES     = 4;
  localparam int unsigned MIN_QUOTE_BYTES = 28;
  localparam int unsigned PORT_TAIL_BYTES = 8;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_SRC_ADDR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_DST_ADDR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_SRC_PORT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_DST_PORT = 8'd3;

  typedef struct packed {
    logic        len_ok;
    logic        kind_ok;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [31:0] ports;
  } chk_t;

endpackage

`default_nettype wire

// ===== design/icmpm_parser.sv =====
// Byte parser: tracks position, header lengths and the quoted addresses and ports.
// Presents the state as it stands after the current byte, with the length checks.
// Depends on icmpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmpm_parser import icmpm_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] packet_byte_i,
  input  wire logic       last_byte_i,
  output chk_t            chk_o
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CW = (PW > 9) ? PW : 9;

  logic [PW-1:0] pos_q, pos_d;
  logic [5:0]    outer_q, outer_d;
  logic          kind_q, kind_d;
  logic [5:0]    inner_q, inner_d;
  logic [31:0]   src_q, src_d;
  logic [31:0]   dst_q, dst_d;
  logic [31:0]   ports_q, ports_d;

  logic          live;
  logic [CW-1:0] p;
  logic [CW-1:0] len;
  logic [CW-1:0] inner_base;
  logic [CW-1:0] port_base;

  always_comb begin
    live       = pos_q < PW'(MAX_PACKET_BYTES);
    p          = CW'(pos_q);
    outer_d    = outer_q;
    kind_d     = kind_q;
    inner_d    = inner_q;
    src_d      = src_q;
    dst_d      = dst_q;
    ports_d    = ports_q;
    pos_d      = pos_q;

    if (live && pos_q == '0) begin
      outer_d = {packet_byte_i[3:0], 2'b00};
    end
    if (live && p == CW'(outer_d)) begin
      kind_d = (packet_byte_i == ICMP_TIME_EXCEEDED) || (packet_byte_i == ICMP_DEST_UNREACH);
    end
    inner_base = CW'(outer_d) + CW'(ICMP_HDR_BYTES);
    if (live && p == inner_base) begin
      inner_d = {packet_byte_i[3:0], 2'b00};
    end
    port_base = inner_base + CW'(inner_d);
    if (live && p >= inner_base + CW'(INNER_SRC_OFF)
        && p < inner_base + CW'(INNER_SRC_OFF + FIELD_BYTES)) begin
      src_d = {src_q[23:0], packet_byte_i};
    end
    if (live && p >= inner_base + CW'(INNER_DST_OFF)
        && p < inner_base + CW'(INNER_DST_OFF + FIELD_BYTES)) begin
      dst_d = {dst_q[23:0], packet_byte_i};
    end
    if (live && p >= port_base && p < port_base + CW'(FIELD_BYTES)) begin
      ports_d = {ports_q[23:0], packet_byte_i};
    end
    if (live) begin
      pos_d = pos_q + PW'(1);
    end

    len = CW'(pos_d);
    chk_o.len_ok   = (len >= CW'(MIN_QUOTE_BYTES))
                  && (len >= CW'(outer_d) + CW'(ICMP_HDR_BYTES))
                  && (len >= inner_base + CW'(MIN_QUOTE_BYTES))
                  && (len >= port_base + CW'(PORT_TAIL_BYTES));
    chk_o.kind_ok  = kind_d;
    chk_o.src_ip   = src_d;
    chk_o.dest_ip  = dst_d;
    chk_o.ports    = ports_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      outer_q <= '0;
      kind_q  <= 1'b0;
      inner_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ports_q <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        outer_q <= '0;
        kind_q  <= 1'b0;
        inner_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        ports_q <= '0;
      end else begin
        pos_q   <= pos_d;
        outer_q <= outer_d;
        kind_q  <= kind_d;
        inner_q <= inner_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        ports_q <= ports_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/icmp_quoted_probe_matcher_unit.sv =====
// ICMP quoted-probe matcher, top level: probe registers, parser and result register.
// Result: the match flag is registered and valid in the cycle after the request carrying the last byte.
// Throughput: one byte per cycle; the input stalls only while a result waits unread.
// Reset: asynchronous, active low; clears probe registers, parse state and result valid.
// Depends on icmpm_pkg and icmpm_parser.
`timescale 1ns / 1ps
`default_nettype none

module icmp_quoted_probe_matcher_unit import icmpm_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [7:0]            packet_byte_i,
  input  wire logic                  last_byte_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  matched_o
);

  logic [31:0] probe_src_ip_q;
  logic [31:0] probe_dest_ip_q;
  logic [15:0] probe_sport_q;
  logic [15:0] probe_dport_q;
  logic        out_valid_q, out_valid_d;
  logic        matched_q, matched_d;
  logic        accept;
  logic        cfg_write;
  logic        hit;
  chk_t        chk;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  icmpm_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .packet_byte_i(packet_byte_i),
    .last_byte_i  (last_byte_i),
    .chk_o        (chk)
  );

  always_comb begin
    hit = chk.len_ok && chk.kind_ok
       && (chk.src_ip == probe_src_ip_q)
       && (chk.dest_ip == probe_dest_ip_q)
       && (chk.ports[31:16] == probe_sport_q)
       && (chk.ports[15:0] == probe_dport_q);
    out_valid_d = out_valid_q & ~out_ready_i;
    matched_d   = matched_q;
    if (accept && last_byte_i) begin
      out_valid_d = 1'b1;
      matched_d   = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_src_ip_q  <= '0;
      probe_dest_ip_q <= '0;
      probe_sport_q   <= '0;
      probe_dport_q   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        REG_PROBE_SRC_ADDR: probe_src_ip_q  <= cfg_data_i;
        REG_PROBE_DST_ADDR: probe_dest_ip_q <= cfg_data_i;
        REG_PROBE_SRC_PORT: probe_sport_q   <= cfg_data_i[15:0];
        REG_PROBE_DST_PORT: probe_dport_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> out_valid_o)
    else $error("last byte accepted without a result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last_byte_i && !out_valid_o |=> !out_valid_o)
    else $error("result raised without a last byte");

  a_cfg_src_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write && cfg_index_i == REG_PROBE_SRC_ADDR |=> probe_src_ip_q == $past(cfg_data_i))
    else $error("probe source address not written");
`endif

endmodule

`default_nettype wire
